### design/bisplit_pkg.sv
`timescale 1ns / 1ps

package bisplit_pkg;

    // Block configuration
    localparam int NUM_PORTS         = 8;
    localparam int MAX_REQUEST_BYTES = 240;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERLEAVE_BITS  = 2'd0;
    localparam logic [1:0] CFG_BANK_SELECT_BITS = 2'd1;
    localparam logic [1:0] CFG_BASE_SUBTRACT    = 2'd2;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_BANK = 1'b1;

    // floor(log2(n)) for elaboration-time constants
    function automatic int floor_log2(input int n);
        int r;
        int p;
        r = 0;
        p = n;
        while (p > 1) begin
            p = p >> 1;
            r = r + 1;
        end
        return r;
    endfunction

    localparam logic [2:0] DEFAULT_SELECT_BITS = 3'(floor_log2(NUM_PORTS));

    // Classified request, handed from front to back
    typedef struct packed {
        logic [31:0] addr;        // rebased address
        logic [7:0]  size;        // saturated byte count, never zero
        logic [15:0] first_len;   // bytes to next port boundary, 0 when aligned
        logic        wr;
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

### design/bisplit_front.sv
`timescale 1ns / 1ps

module bisplit_front
    import bisplit_pkg::*;
(
    input  logic [31:0] address,
    input  logic [7:0]  byte_count,
    input  logic        wr_flag,
    input  logic [3:0]  interleave_bits,
    input  logic [31:0] base_subtract,
    output logic        drop,
    output req_t        req
);

    logic [15:0] port_len;
    logic [15:0] low_part;
    logic [15:0] low_mask;

    always_comb
    begin
        port_len  = 16'd1 << interleave_bits;
        low_mask  = port_len - 16'd1;
        // boundary taken on the address before rebasing
        low_part  = address[15:0] & low_mask;

        req.addr      = address - base_subtract;
        req.size      = (byte_count > 8'(MAX_REQUEST_BYTES)) ? 8'(MAX_REQUEST_BYTES)
                                                             : byte_count;
        req.first_len = (low_part == 16'd0) ? 16'd0 : (port_len - low_part);
        req.wr        = wr_flag;

        // zero-size requests produce nothing
        drop = (byte_count == 8'd0);
    end

endmodule

### design/bisplit_queue.sv
`timescale 1ns / 1ps

module bisplit_queue
    import bisplit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    input  logic pop,
    output req_t pop_data,
    output logic full,
    output logic empty
);

    req_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/bisplit_back.sv
`timescale 1ns / 1ps

module bisplit_back
    import bisplit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  interleave_bits,
    input  logic [2:0]  bank_select_bits,
    input  logic        q_empty,
    input  req_t        q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    state_t      state_reg;
    state_t      state_next;

    // working copy of the request being split
    logic [31:0] addr_reg;
    logic [31:0] addr_next;
    logic [7:0]  size_reg;
    logic [7:0]  size_next;
    logic [7:0]  done_reg;
    logic [7:0]  done_next;
    logic [15:0] first_reg;
    logic [15:0] first_next;
    logic        wr_reg;
    logic        wr_next;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [5:0]  out_bank_reg;
    logic [5:0]  out_bank_next;
    logic [31:0] out_addr_reg;
    logic [31:0] out_addr_next;
    logic [7:0]  out_bytes_reg;
    logic [7:0]  out_bytes_next;
    logic [7:0]  out_off_reg;
    logic [7:0]  out_off_next;
    logic        out_wr_reg;
    logic        out_wr_next;
    logic        out_status_reg;
    logic        out_status_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        out_free;
    logic        emit;
    logic [2:0]  sel_bits;
    logic [4:0]  hi_shift;
    logic [15:0] port_len;
    logic [15:0] chunk_cand;
    logic [7:0]  remain;
    logic [7:0]  chunk;
    logic        chunk_last;
    logic [6:0]  bank_full;
    logic        bad_bank;
    logic [31:0] low_mask;
    logic [31:0] high_mask;
    logic [31:0] local_addr;
    logic        req_end;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (state_reg == ST_RUN) && out_free;

    // chunk datapath
    always_comb
    begin
        sel_bits   = (bank_select_bits == 3'd0) ? DEFAULT_SELECT_BITS : bank_select_bits;
        hi_shift   = 5'(interleave_bits) + 5'(sel_bits);
        port_len   = 16'd1 << interleave_bits;
        chunk_cand = (first_reg != 16'd0) ? first_reg : port_len;
        remain     = size_reg - done_reg;
        chunk      = (chunk_cand > 16'(remain)) ? remain : chunk_cand[7:0];
        chunk_last = (chunk == remain);
        bank_full  = 7'((addr_reg >> interleave_bits) & ~(32'hFFFF_FFFF << sel_bits));
        bad_bank   = (bank_full >= 7'(NUM_PORTS));
        low_mask   = ~(32'hFFFF_FFFF << interleave_bits);
        high_mask  = 32'hFFFF_FFFF << hi_shift;
        local_addr = ((addr_reg & high_mask) >> sel_bits) + (addr_reg & low_mask);
        req_end    = bad_bank || chunk_last;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && req_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb
    begin
        q_pop           = 1'b0;
        addr_next       = addr_reg;
        size_next       = size_reg;
        done_next       = done_reg;
        first_next      = first_reg;
        wr_next         = wr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_bank_next   = out_bank_reg;
        out_addr_next   = out_addr_reg;
        out_bytes_next  = out_bytes_reg;
        out_off_next    = out_off_reg;
        out_wr_next     = out_wr_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    addr_next  = q_data.addr;
                    size_next  = q_data.size;
                    done_next  = 8'd0;
                    first_next = q_data.first_len;
                    wr_next    = q_data.wr;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = done_reg;
                    out_wr_next    = wr_reg;
                    if (bad_bank)
                    begin
                        out_bank_next   = 6'd0;
                        out_addr_next   = 32'd0;
                        out_bytes_next  = 8'd0;
                        out_status_next = STATUS_BAD_BANK;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        out_bank_next   = bank_full[5:0];
                        out_addr_next   = local_addr;
                        out_bytes_next  = chunk;
                        out_status_next = STATUS_OK;
                        out_last_next   = chunk_last;
                    end
                    done_next  = done_reg + chunk;
                    addr_next  = addr_reg + 32'(chunk);
                    first_next = 16'd0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        done_reg       <= done_next;
        first_reg      <= first_next;
        wr_reg         <= wr_next;
        out_bank_reg   <= out_bank_next;
        out_addr_reg   <= out_addr_next;
        out_bytes_reg  <= out_bytes_next;
        out_off_reg    <= out_off_next;
        out_wr_reg     <= out_wr_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_off_reg, 5'd0, out_bytes_reg, out_addr_reg, out_bank_reg};
    assign m_tuser  = {out_status_reg, out_wr_reg};
    assign m_tlast  = out_last_reg;

endmodule

### design/bank_interleave_request_splitter.sv
`timescale 1ns / 1ps

// Bank interleave request splitter.
// Input stream (s_*): one memory request per transfer - start address, byte
// count and write flag. Output stream (m_*): one transfer per bank chunk with
// bank index, bank-local address, chunk size and byte offset into the request;
// tlast marks the final chunk of a request. A chunk whose bank index is not a
// valid port is replaced by a single error transfer (tuser status set, tlast
// set) and the request ends there. Zero-byte requests are consumed silently.
// The front classifies each request in the accept cycle and writes it into a
// two-entry queue; the back splits one request at a time.
// A request passes through the queue, the back's working registers and the
// output register before its first chunk appears on m_tvalid.
// Throughput: one chunk per cycle while the receiver does not stall; each
// request is loaded from the queue before its first chunk is split.
// Reset clears the queue, the splitter state and the output valid; the config
// registers return to interleave 2, select bits 3, base 0.
// When the receiver stalls the output register holds its transfer, the back
// waits, and once the queue is full s_tready drops.
// Configuration writes take effect at once and are meant for idle periods.

module bank_interleave_request_splitter
    import bisplit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // address[31:0], byte_count[39:32]
    input  logic        s_tuser,    // write flag

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // bank_index[5:0], bank_address[37:6],
                                    // chunk_bytes[50:38], data_offset[58:51], zero pad
    output logic [1:0]  m_tuser,    // chunk_write[0], status[1]
    output logic        m_tlast
);

    logic [3:0]  interleave_bits_reg;
    logic [2:0]  bank_select_bits_reg;
    logic [31:0] base_subtract_reg;

    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        drop;
    req_t        front_req;
    req_t        q_head;

    // Configuration registers: index out of range is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interleave_bits_reg  <= 4'd2;
            bank_select_bits_reg <= 3'd3;
            base_subtract_reg    <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERLEAVE_BITS:  interleave_bits_reg  <= cfg_data[3:0];
                CFG_BANK_SELECT_BITS: bank_select_bits_reg <= cfg_data[2:0];
                CFG_BASE_SUBTRACT:    base_subtract_reg    <= cfg_data;
                default:              base_subtract_reg    <= base_subtract_reg;
            endcase
        end
    end

    // Accept whenever the queue has room; zero-size requests are dropped here.
    assign s_tready = !q_full;

    bisplit_front u_front (
        .address         (s_tdata[31:0]),
        .byte_count      (s_tdata[39:32]),
        .wr_flag         (s_tuser),
        .interleave_bits (interleave_bits_reg),
        .base_subtract   (base_subtract_reg),
        .drop            (drop),
        .req             (front_req)
    );

    bisplit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && !drop),
        .push_data (front_req),
        .pop       (q_pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bisplit_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .interleave_bits  (interleave_bits_reg),
        .bank_select_bits (bank_select_bits_reg),
        .q_empty          (q_empty),
        .q_data           (q_head),
        .q_pop            (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

endmodule

### test/bisplit_chunk_checker.sv
`timescale 1ns / 1ps

module bisplit_chunk_checker
    import bisplit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // address[31:0], byte_count[39:32]
    input  logic        s_tuser,    // write flag

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // bank_index[5:0], bank_address[37:6],
                                    // chunk_bytes[50:38], data_offset[58:51]
    input  logic [1:0]  m_tuser,    // chunk_write[0], status[1]
    input  logic        m_tlast,

    output int unsigned failures,
    output int unsigned chunks_outstanding
);

    typedef struct packed {
        logic [5:0]  bank;
        logic [31:0] addr;
        logic [12:0] bytes;
        logic [7:0]  offset;
        logic        wr;
        logic        status;
        logic        last;
    } chunk_t;

    // shadow of the block's registers
    logic [3:0]  reg_interleave = 4'd2;
    logic [2:0]  reg_select     = 3'd3;
    logic [31:0] reg_base       = 32'd0;

    chunk_t      pending_chunks[$];
    int unsigned fail_total;

    // Work out every chunk of one request and queue them in output order.
    function automatic void split_request(input logic [31:0] address,
                                          input logic [7:0]  byte_count,
                                          input logic        wr);
        logic [31:0] rebased;
        logic [31:0] port_bytes;
        logic [31:0] low_mask;
        logic [31:0] high_mask;
        logic [31:0] sel_mask;
        logic [31:0] first_len;
        logic [31:0] done;
        logic [31:0] total;
        logic [31:0] piece;
        logic [31:0] remain;
        logic [31:0] bank;
        logic [31:0] bank_local;
        int unsigned ilv;
        int unsigned sel;
        chunk_t      c;

        ilv        = reg_interleave;
        sel        = (reg_select != 3'd0) ? reg_select : DEFAULT_SELECT_BITS;
        port_bytes = 32'd1 << ilv;
        low_mask   = port_bytes - 32'd1;
        high_mask  = ~((32'd1 << (ilv + sel)) - 32'd1);
        sel_mask   = (32'd1 << sel) - 32'd1;
        total      = (byte_count > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : byte_count;

        // the first boundary is taken from the address before rebasing
        first_len = address & low_mask;
        if (first_len != 32'd0)
            first_len = port_bytes - first_len;
        rebased = address - reg_base;
        done    = 32'd0;

        while (done < total)
        begin
            piece  = port_bytes;
            remain = total - done;
            if (first_len != 32'd0)
            begin
                piece     = first_len;
                first_len = 32'd0;
            end
            if (piece > remain)
                piece = remain;

            bank     = (rebased >> ilv) & sel_mask;
            c.wr     = wr;
            c.offset = done[7:0];
            if (bank >= NUM_PORTS)
            begin
                c.bank   = '0;
                c.addr   = '0;
                c.bytes  = '0;
                c.status = STATUS_BAD_BANK;
                c.last   = 1'b1;
                pending_chunks.push_back(c);
                return;
            end
            bank_local = ((rebased & high_mask) >> sel) + (rebased & low_mask);
            c.bank     = bank[5:0];
            c.addr     = bank_local;
            c.bytes    = piece[12:0];
            c.status   = STATUS_OK;
            c.last     = (piece == remain);
            pending_chunks.push_back(c);
            done    = done + piece;
            rebased = rebased + piece;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        chunk_t got;
        chunk_t want;
        logic   bad;

        if (!rst_n)
        begin
            reg_interleave = 4'd2;
            reg_select     = 3'd3;
            reg_base       = 32'd0;
            pending_chunks.delete();
            fail_total = 0;
            failures           <= 0;
            chunks_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INTERLEAVE_BITS:  reg_interleave = cfg_data[3:0];
                    CFG_BANK_SELECT_BITS: reg_select     = cfg_data[2:0];
                    CFG_BASE_SUBTRACT:    reg_base       = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.bank   = m_tdata[5:0];
                got.addr   = m_tdata[37:6];
                got.bytes  = m_tdata[50:38];
                got.offset = m_tdata[58:51];
                got.wr     = m_tuser[0];
                got.status = m_tuser[1];
                got.last   = m_tlast;
                if (pending_chunks.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: chunk with none pending: bank %0d addr %08h bytes %0d",
                                 $realtime, got.bank, got.addr, got.bytes);
                end
                else
                begin
                    want = pending_chunks.pop_front();
                    bad  = (got.bank !== want.bank) || (got.addr !== want.addr)
                        || (got.bytes !== want.bytes) || (got.offset !== want.offset)
                        || (got.wr !== want.wr) || (got.status !== want.status)
                        || (got.last !== want.last);
                    if (bad)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("%0t: chunk mismatch", $realtime);
                            $display("  exp bank %0d addr %08h bytes %0d off %0d",
                                     want.bank, want.addr, want.bytes, want.offset);
                            $display("      wr %b st %b last %b",
                                     want.wr, want.status, want.last);
                            $display("  got bank %0d addr %08h bytes %0d off %0d",
                                     got.bank, got.addr, got.bytes, got.offset);
                            $display("      wr %b st %b last %b",
                                     got.wr, got.status, got.last);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
                split_request(s_tdata[31:0], s_tdata[39:32], s_tuser);

            failures           <= fail_total;
            chunks_outstanding <= pending_chunks.size();
        end
    end

endmodule

### test/tb_bank_interleave_request_splitter.sv
`timescale 1ns / 1ps

module tb_bank_interleave_request_splitter;
    import bisplit_pkg::*;

    // Cycles of receiver hold-off used to fill the request queue, and the
    // number of cycles without any transfer after which the run is abandoned.
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_INTERLEAVE_BITS;
    logic [31:0] cfg_data  = 32'd0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = 40'd0;    // address[31:0], byte_count[39:32]
    logic        s_tuser   = 1'b0;     // write flag

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;              // bank_index[5:0], bank_address[37:6],
                                       // chunk_bytes[50:38], data_offset[58:51]
    logic [1:0]  m_tuser;              // chunk_write[0], status[1]
    logic        m_tlast;

    int unsigned failures;
    int unsigned chunks_outstanding;

    // Idling percentages for each side, and the one-shot request for a long
    // receiver hold-off.
    int unsigned tx_idle_pct = 9;
    int unsigned rx_idle_pct = 51;
    bit          hold_request = 1'b0;

    // Configuration as last written, used to aim addresses at valid banks.
    logic [3:0]  cur_ilv  = 4'd2;
    logic [31:0] cur_base = 32'd0;

    int unsigned requests_sent = 0;
    int unsigned idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bank_interleave_request_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The checker sees every channel, predicts the chunks and hands back the
    // failure count and how many chunks it is still waiting for.
    bisplit_chunk_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .m_tlast            (m_tlast),
        .failures           (failures),
        .chunks_outstanding (chunks_outstanding)
    );

    // Offer one request and hold it until the transfer happens. Idle cycles
    // are inserted beforehand at the sender's current rate. Returns at the
    // edge where the transfer took place, with nothing scheduled yet.
    task automatic send_request(input logic [31:0] address, input logic [7:0] count,
                                input logic wr);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {count, address};
        s_tuser  <= wr;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop the input valid and wait for every predicted chunk to come out.
    // The trailing cycles let the block settle before the registers change.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chunks_outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; the block must be idle.
    task automatic load_config(input logic [3:0] ilv, input logic [2:0] sel,
                               input logic [31:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERLEAVE_BITS;
        cfg_data  <= {28'd0, ilv};
        @(posedge clk);
        cfg_index <= CFG_BANK_SELECT_BITS;
        cfg_data  <= {29'd0, sel};
        @(posedge clk);
        cfg_index <= CFG_BASE_SUBTRACT;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_ilv   = ilv;
        cur_base  = base;
    endtask

    // Receiver: accept at random at the current idling rate. On request,
    // hold off for a long stretch so that the queue fills and the input
    // stalls while the sender keeps offering.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: abandon the run when no transfer moves on either side for
    // too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("[bank_interleave_request_splitter] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          n;
        int unsigned pick;
        logic [3:0]  ilv_v;
        logic [2:0]  sel_v;
        logic [31:0] base_v;
        logic [31:0] addr_v;
        logic [7:0]  count_v;

        // Hold reset, then release it on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, under the reset settings (port of 4 bytes, 3 select bits):
        // zero size, single byte, the largest request, oversized counts that
        // saturate, and addresses that wrap past the top.
        send_request(32'h0000_0000, 8'd0,   1'b0);
        send_request(32'h0000_0000, 8'd1,   1'b1);
        send_request(32'h0000_0000, 8'd240, 1'b0);
        send_request(32'h0000_0003, 8'd255, 1'b1);
        send_request(32'hFFFF_FFFF, 8'd241, 1'b0);
        send_request(32'hFFFF_FFF0, 8'd32,  1'b1);
        send_request(32'h1234_5679, 8'd7,   1'b0);

        // Unaligned base: the first chunk follows the unrebased boundary.
        // Five select bits let banks run past the port count: one request
        // fails at once, one part way through, one after a wrapped rebase.
        wait_drained();
        load_config(4'd4, 3'd5, 32'h0000_0007);
        send_request(32'h0000_0007, 8'd64,  1'b1);
        send_request(32'h0000_0087, 8'd16,  1'b0);
        send_request(32'h0000_0067, 8'd100, 1'b1);
        send_request(32'h0000_0000, 8'd8,   1'b0);
        send_request(32'hFFFF_FFFF, 8'd0,   1'b1);

        // Widest register values and the largest base.
        wait_drained();
        load_config(4'd15, 3'd7, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 8'd240, 1'b0);
        send_request(32'h0004_8000, 8'd200, 1'b1);
        send_request(32'hFFFF_FFFF, 8'd255, 1'b1);

        // Select bits of zero fall back to the default for the port count.
        wait_drained();
        load_config(4'd2, 3'd0, 32'h0000_0000);
        send_request(32'h0000_001F, 8'd40,  1'b1);
        send_request(32'hFFFF_FFFE, 8'd9,   1'b0);

        // Random phases, each with its own settings, extremes first.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ilv_v  = 4'd2;
                    sel_v  = 3'd3;
                    base_v = 32'd0;
                end
                1:
                begin
                    ilv_v  = 4'd12;
                    sel_v  = 3'd6;
                    base_v = $urandom;
                end
                2:
                begin
                    ilv_v  = 4'd15;
                    sel_v  = 3'd0;
                    base_v = 32'hFFFF_FFFF;
                end
                3:
                begin
                    ilv_v  = 4'd2;
                    sel_v  = 3'd7;
                    base_v = $urandom;
                end
                default:
                begin
                    ilv_v  = 4'($urandom_range(2, 15));
                    sel_v  = 3'($urandom_range(0, 7));
                    base_v = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
                end
            endcase
            wait_drained();
            load_config(ilv_v, sel_v, base_v);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Sender idles lightly and the receiver heavily, then the
                // other way round, then neither.
                if (requests_sent < 170)
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 51;
                end
                else if (requests_sent < 340)
                begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 9;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (requests_sent == 400)
                    hold_request = 1'b1;

                // Mostly aim at valid banks just above the base; some
                // requests near the top of the address space, the rest
                // anywhere.
                pick = $urandom_range(99);
                if (pick < 60)
                    addr_v = cur_base + ($urandom & ((32'd8 << cur_ilv) - 32'd1));
                else if (pick < 70)
                    addr_v = 32'hFFFF_FFFF - $urandom_range(0, 255);
                else
                    addr_v = $urandom;

                pick = $urandom_range(99);
                if (pick < 5)
                    count_v = 8'd0;
                else if (pick < 12)
                    count_v = 8'($urandom_range(241, 255));
                else if (pick < 20)
                    count_v = 8'd240;
                else
                    count_v = 8'($urandom_range(1, 240));

                send_request(addr_v, count_v, 1'($urandom_range(0, 1)));
                requests_sent++;
            end
        end

        // Let the last chunks drain, then allow a few more cycles for any
        // stray transfer to show up.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chunks_outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0 && chunks_outstanding == 0)
            $display("[bank_interleave_request_splitter] OK");
        else
            $display("[bank_interleave_request_splitter] ERROR");
        $finish;
    end

endmodule

### files.f
design/bisplit_pkg.sv
design/bisplit_front.sv
design/bisplit_queue.sv
design/bisplit_back.sv
design/bank_interleave_request_splitter.sv
test/bisplit_chunk_checker.sv
test/tb_bank_interleave_request_splitter.sv
